@@ hw/rtl/dtq_pkg.sv @@
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types, widths and helpers for the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int DTQ_HEAP_DEPTH = 32;
    localparam int DTQ_KIND_COUNT = 16;

    localparam int TIME_W   = 48;
    localparam int KIND_W   = 4;
    localparam int GEN_W    = 32;
    localparam int BUDGET_W = 31;
    localparam int OP_W     = 3;

    typedef enum logic [OP_W-1:0] {
        OP_SCHEDULE  = 3'd0,
        OP_CANCEL    = 3'd1,
        OP_SET_TIME  = 3'd2,
        OP_POP_DUE   = 3'd3,
        OP_BEGIN     = 3'd4,
        OP_END       = 3'd5,
        OP_READ_TIME = 3'd6,
        OP_CLEAR     = 3'd7
    } op_t;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [KIND_W-1:0] kind;
        logic [GEN_W-1:0]  gen;
    } heap_entry_t;

    // increment, skipping zero
    function automatic logic [GEN_W-1:0] bump_gen(input logic [GEN_W-1:0] g);
        logic [GEN_W-1:0] n;
        n = g + GEN_W'(1);
        return (n == '0) ? GEN_W'(1) : n;
    endfunction

endpackage

@@ hw/rtl/device_deadline_timer_queue.sv @@
// ----------------------------------------------------------------------------
// device_deadline_timer_queue
// Min-heap deadline queue with per-kind generations and lazy stale discard.
// ----------------------------------------------------------------------------
// Operation: one item at a time; each request runs its op, then the stale
//   scan. Schedule sifts up level by level; each removal reads the last
//   entry, then sifts down level by level; each top check reads top and gen.
// Throughput: next request taken once the result is handed to the output
//   register; all heap traffic goes through one single-port-read memory.
// Reset: async, clears count, time, slice and generation valid bits.
//   Heap contents stay undefined; no clearing pass is needed.
module device_deadline_timer_queue
    import dtq_pkg::*;
#(
    parameter int HEAP_DEPTH = DTQ_HEAP_DEPTH,
    parameter int KIND_COUNT = DTQ_KIND_COUNT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     opcode,
    input  logic [KIND_W-1:0]   device_kind,
    input  logic [TIME_W-1:0]   time_value,
    input  logic [BUDGET_W-1:0] budget,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [TIME_W-1:0]   next_deadline,
    output logic                deadline_valid,
    output logic [KIND_W-1:0]   due_kind,
    output logic                due_valid,
    output logic                yield_request,
    output logic [TIME_W-1:0]   current_time,
    output logic                overflow
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int KW = $clog2(KIND_COUNT);

    typedef enum logic [14:0] {
        ST_IDLE    = 15'h0001,
        ST_EXEC    = 15'h0002,
        ST_GEN     = 15'h0004,
        ST_UP      = 15'h0008,
        ST_UP_CMP  = 15'h0010,
        ST_DROP    = 15'h0020,
        ST_DR_TOP  = 15'h0040,
        ST_DR_GEN  = 15'h0080,
        ST_RM_RD   = 15'h0100,
        ST_RM_LAST = 15'h0200,
        ST_DOWN    = 15'h0400,
        ST_DN_C1   = 15'h0800,
        ST_DN_C2   = 15'h1000,
        ST_DN_CMP  = 15'h2000,
        ST_DONE    = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    // latched request
    op_t                 op_reg, op_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [TIME_W-1:0]   tv_reg, tv_next;
    logic [BUDGET_W-1:0] bud_reg, bud_next;

    // architectural state
    logic [CW-1:0]       count_reg, count_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic                active_reg, active_next;
    logic [TIME_W-1:0]   base_reg, base_next;
    logic [BUDGET_W-1:0] sbud_reg, sbud_next;
    logic [TIME_W-1:0]   target_reg, target_next;

    // work registers
    heap_entry_t         mv_reg, mv_next;      // entry being placed
    heap_entry_t         top_reg, top_next;
    heap_entry_t         best_reg, best_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]       up_reg, up_next;
    logic [AW-1:0]       cidx_reg, cidx_next;
    logic [AW-1:0]       bidx_reg, bidx_next;
    logic                pop_pend_reg, pop_pend_next;

    // per-request result flags
    logic [TIME_W-1:0]   rt_reg, rt_next;
    logic [TIME_W-1:0]   nd_reg, nd_next;
    logic                dv_reg, dv_next;
    logic [KIND_W-1:0]   dk_reg, dk_next;
    logic                duev_reg, duev_next;
    logic                yld_reg, yld_next;
    logic                ovf_reg, ovf_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [TIME_W-1:0]   o_nd_reg, o_nd_next;
    logic                o_dv_reg, o_dv_next;
    logic [KIND_W-1:0]   o_dk_reg, o_dk_next;
    logic                o_duev_reg, o_duev_next;
    logic                o_yld_reg, o_yld_next;
    logic [TIME_W-1:0]   o_cur_reg, o_cur_next;
    logic                o_ovf_reg, o_ovf_next;

    // memory ports
    logic             h_rd_en, h_wr_en;
    logic [AW-1:0]    h_rd_addr, h_wr_addr;
    heap_entry_t      h_rd_data, h_wr_data;
    logic             g_rd_en, g_wr_en;
    logic [KW-1:0]    g_rd_addr, g_wr_addr;
    logic [GEN_W-1:0] g_rd_data, g_wr_data;

    dtq_heap_mem #(.DEPTH(HEAP_DEPTH), .AW(AW)) u_heap (
        .clk     (clk),
        .rd_en   (h_rd_en),
        .rd_addr (h_rd_addr),
        .rd_data (h_rd_data),
        .wr_en   (h_wr_en),
        .wr_addr (h_wr_addr),
        .wr_data (h_wr_data)
    );

    dtq_gen_mem #(.KINDS(KIND_COUNT), .KW(KW)) u_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (g_rd_en),
        .rd_addr (g_rd_addr),
        .rd_data (g_rd_data),
        .wr_en   (g_wr_en),
        .wr_addr (g_wr_addr),
        .wr_data (g_wr_data)
    );

    logic              kind_ok;
    logic [GEN_W-1:0]  gen_new;
    logic [TIME_W:0]   tgt_sum;
    logic [CW-1:0]     cidx_ext;
    logic [CW-1:0]     pos_ext;

    assign kind_ok  = 32'(kind_reg) < KIND_COUNT;
    assign gen_new  = bump_gen(g_rd_data);
    assign tgt_sum  = {1'b0, now_reg} + (TIME_W+1)'(bud_reg);
    assign cidx_ext = CW'(cidx_reg);
    assign pos_ext  = CW'(pos_reg);

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        kind_next      = kind_reg;
        tv_next        = tv_reg;
        bud_next       = bud_reg;
        count_next     = count_reg;
        now_next       = now_reg;
        active_next    = active_reg;
        base_next      = base_reg;
        sbud_next      = sbud_reg;
        target_next    = target_reg;
        mv_next        = mv_reg;
        top_next       = top_reg;
        best_next      = best_reg;
        pos_next       = pos_reg;
        up_next        = up_reg;
        cidx_next      = cidx_reg;
        bidx_next      = bidx_reg;
        pop_pend_next  = pop_pend_reg;
        rt_next        = rt_reg;
        nd_next        = nd_reg;
        dv_next        = dv_reg;
        dk_next        = dk_reg;
        duev_next      = duev_reg;
        yld_next       = yld_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        o_nd_next      = o_nd_reg;
        o_dv_next      = o_dv_reg;
        o_dk_next      = o_dk_reg;
        o_duev_next    = o_duev_reg;
        o_yld_next     = o_yld_reg;
        o_cur_next     = o_cur_reg;
        o_ovf_next     = o_ovf_reg;

        h_rd_en   = 1'b0;
        h_rd_addr = '0;
        h_wr_en   = 1'b0;
        h_wr_addr = '0;
        h_wr_data = mv_reg;
        g_rd_en   = 1'b0;
        g_rd_addr = KW'(kind_reg);
        g_wr_en   = 1'b0;
        g_wr_addr = KW'(kind_reg);
        g_wr_data = gen_new;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = op_t'(opcode);
                    kind_next     = device_kind;
                    tv_next       = time_value;
                    bud_next      = budget;
                    dk_next       = '0;
                    duev_next     = 1'b0;
                    yld_next      = 1'b0;
                    ovf_next      = 1'b0;
                    pop_pend_next = 1'b0;
                    state_next    = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_DROP;
                unique case (op_reg)
                    OP_SCHEDULE, OP_CANCEL:
                    begin
                        if (kind_ok)
                        begin
                            g_rd_en    = 1'b1;
                            state_next = ST_GEN;
                        end
                    end
                    OP_SET_TIME:  now_next = tv_reg;
                    OP_POP_DUE:   pop_pend_next = 1'b1;
                    OP_BEGIN:
                    begin
                        active_next = 1'b1;
                        base_next   = now_reg;
                        sbud_next   = bud_reg;
                        target_next = tgt_sum[TIME_W] ? '1 : tgt_sum[TIME_W-1:0];
                    end
                    OP_END:       active_next = 1'b0;
                    OP_READ_TIME:
                    begin
                        // remaining budget above slice budget wraps
                        rt_next = base_reg + TIME_W'(sbud_reg) - TIME_W'(bud_reg);
                    end
                    OP_CLEAR:     count_next = '0;
                    default:      state_next = ST_DROP;
                endcase
            end

            ST_GEN:
            begin
                g_wr_en    = 1'b1;
                state_next = ST_DROP;
                if (op_reg == OP_SCHEDULE)
                begin
                    yld_next = active_reg && (tv_reg <= target_reg);
                    if (count_reg < CW'(HEAP_DEPTH))
                    begin
                        mv_next    = '{deadline: tv_reg, kind: kind_reg, gen: gen_new};
                        pos_next   = AW'(count_reg);
                        count_next = count_reg + CW'(1);
                        state_next = ST_UP;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end

            ST_UP:
            begin
                if (pos_reg == '0)
                begin
                    h_wr_en    = 1'b1;
                    h_wr_addr  = pos_reg;
                    state_next = ST_DROP;
                end
                else
                begin
                    h_rd_en    = 1'b1;
                    h_rd_addr  = (pos_reg - AW'(1)) >> 1;
                    up_next    = (pos_reg - AW'(1)) >> 1;
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP:
            begin
                h_wr_en   = 1'b1;
                h_wr_addr = pos_reg;
                if (h_rd_data.deadline <= mv_reg.deadline)
                begin
                    state_next = ST_DROP;
                end
                else
                begin
                    h_wr_data  = h_rd_data;
                    pos_next   = up_reg;
                    state_next = ST_UP;
                end
            end

            ST_DROP:
            begin
                if (count_reg == '0)
                begin
                    pop_pend_next = 1'b0;
                    nd_next       = '1;
                    dv_next       = 1'b0;
                    state_next    = ST_DONE;
                end
                else
                begin
                    h_rd_en    = 1'b1;
                    h_rd_addr  = '0;
                    state_next = ST_DR_TOP;
                end
            end

            ST_DR_TOP:
            begin
                top_next = h_rd_data;
                if (32'(h_rd_data.kind) < KIND_COUNT)
                begin
                    g_rd_en    = 1'b1;
                    g_rd_addr  = KW'(h_rd_data.kind);
                    state_next = ST_DR_GEN;
                end
                else
                begin
                    state_next = ST_RM_RD;
                end
            end

            ST_DR_GEN:
            begin
                if (g_rd_data != top_reg.gen)
                begin
                    state_next = ST_RM_RD;          // stale top
                end
                else if (pop_pend_reg && (top_reg.deadline <= now_reg))
                begin
                    dk_next       = top_reg.kind;
                    duev_next     = 1'b1;
                    pop_pend_next = 1'b0;
                    state_next    = ST_RM_RD;
                end
                else
                begin
                    pop_pend_next = 1'b0;
                    nd_next       = top_reg.deadline;
                    dv_next       = 1'b1;
                    state_next    = ST_DONE;
                end
            end

            ST_RM_RD:
            begin
                h_rd_en    = 1'b1;
                h_rd_addr  = AW'(count_reg - CW'(1));
                state_next = ST_RM_LAST;
            end

            ST_RM_LAST:
            begin
                mv_next    = h_rd_data;
                count_next = count_reg - CW'(1);
                pos_next   = '0;
                state_next = (count_reg == CW'(1)) ? ST_DROP : ST_DOWN;
            end

            ST_DOWN:
            begin
                if (pos_ext < (count_reg >> 1))
                begin
                    h_rd_en    = 1'b1;
                    h_rd_addr  = AW'({pos_ext, 1'b1});
                    cidx_next  = AW'({pos_ext, 1'b1});
                    state_next = ST_DN_C1;
                end
                else
                begin
                    h_wr_en    = 1'b1;
                    h_wr_addr  = pos_reg;
                    state_next = ST_DROP;
                end
            end

            ST_DN_C1:
            begin
                best_next = h_rd_data;
                bidx_next = cidx_reg;
                if ((cidx_ext + CW'(1)) < count_reg)
                begin
                    h_rd_en    = 1'b1;
                    h_rd_addr  = cidx_reg + AW'(1);
                    state_next = ST_DN_C2;
                end
                else
                begin
                    state_next = ST_DN_CMP;
                end
            end

            ST_DN_C2:
            begin
                if (h_rd_data.deadline < best_reg.deadline)
                begin
                    best_next = h_rd_data;
                    bidx_next = cidx_reg + AW'(1);
                end
                state_next = ST_DN_CMP;
            end

            ST_DN_CMP:
            begin
                h_wr_en   = 1'b1;
                h_wr_addr = pos_reg;
                if (best_reg.deadline >= mv_reg.deadline)
                begin
                    state_next = ST_DROP;
                end
                else
                begin
                    h_wr_data  = best_reg;
                    pos_next   = bidx_reg;
                    state_next = ST_DOWN;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_nd_next      = nd_reg;
                    o_dv_next      = dv_reg;
                    o_dk_next      = dk_reg;
                    o_duev_next    = duev_reg;
                    o_yld_next     = yld_reg;
                    o_ovf_next     = ovf_reg;
                    o_cur_next     = (op_reg == OP_READ_TIME && active_reg) ? rt_reg : now_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            now_reg       <= '0;
            active_reg    <= 1'b0;
            base_reg      <= '0;
            sbud_reg      <= '0;
            target_reg    <= '0;
            pop_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            now_reg       <= now_next;
            active_reg    <= active_next;
            base_reg      <= base_next;
            sbud_reg      <= sbud_next;
            target_reg    <= target_next;
            pop_pend_reg  <= pop_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        kind_reg   <= kind_next;
        tv_reg     <= tv_next;
        bud_reg    <= bud_next;
        mv_reg     <= mv_next;
        top_reg    <= top_next;
        best_reg   <= best_next;
        pos_reg    <= pos_next;
        up_reg     <= up_next;
        cidx_reg   <= cidx_next;
        bidx_reg   <= bidx_next;
        rt_reg     <= rt_next;
        nd_reg     <= nd_next;
        dv_reg     <= dv_next;
        dk_reg     <= dk_next;
        duev_reg   <= duev_next;
        yld_reg    <= yld_next;
        ovf_reg    <= ovf_next;
        o_nd_reg   <= o_nd_next;
        o_dv_reg   <= o_dv_next;
        o_dk_reg   <= o_dk_next;
        o_duev_reg <= o_duev_next;
        o_yld_reg  <= o_yld_next;
        o_cur_reg  <= o_cur_next;
        o_ovf_reg  <= o_ovf_next;
    end

    assign out_valid      = out_valid_reg;
    assign next_deadline  = o_nd_reg;
    assign deadline_valid = o_dv_reg;
    assign due_kind       = o_dk_reg;
    assign due_valid      = o_duev_reg;
    assign yield_request  = o_yld_reg;
    assign current_time   = o_cur_reg;
    assign overflow       = o_ovf_reg;

    // sequencer state stays one-hot
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");

    // heap occupancy never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HEAP_DEPTH))
        else $error("heap count overrun");

    // an empty queue reports the all-ones deadline
    a_empty_deadline: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !deadline_valid) |-> (next_deadline == '1))
        else $error("empty queue with a deadline");

    // a generation update never overlaps a generation read
    a_gen_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(g_wr_en && g_rd_en))
        else $error("generation store read and write together");

endmodule

@@ hw/rtl/dtq_heap_mem.sv @@
// ----------------------------------------------------------------------------
// dtq_heap_mem
// Heap entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dtq_heap_mem
    import dtq_pkg::*;
#(
    parameter int DEPTH = DTQ_HEAP_DEPTH,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic        clk,
    input  logic        rd_en,
    input  logic [AW-1:0] rd_addr,
    output heap_entry_t rd_data,
    input  logic        wr_en,
    input  logic [AW-1:0] wr_addr,
    input  heap_entry_t wr_data
);

    heap_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/dtq_gen_mem.sv @@
// ----------------------------------------------------------------------------
// dtq_gen_mem
// Per-kind generation store; valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module dtq_gen_mem
    import dtq_pkg::*;
#(
    parameter int KINDS = DTQ_KIND_COUNT,
    parameter int KW    = $clog2(KINDS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [KW-1:0]    rd_addr,
    output logic [GEN_W-1:0] rd_data,
    input  logic             wr_en,
    input  logic [KW-1:0]    wr_addr,
    input  logic [GEN_W-1:0] wr_data
);

    logic [GEN_W-1:0] mem [KINDS];
    logic [KINDS-1:0] valid_reg;
    logic             rd_valid_reg;
    logic [GEN_W-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives timer queue requests through the valid/ready channel and compares
// every response, field by field, against a behavioral heap model.
// ----------------------------------------------------------------------------
module testbench;
    import dtq_pkg::*;

    localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic [TIME_W-1:0] next_deadline;
        logic              deadline_valid;
        logic [KIND_W-1:0] due_kind;
        logic              due_valid;
        logic              yield_request;
        logic [TIME_W-1:0] current_time;
        logic              overflow;
    } resp_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     opcode;
    logic [KIND_W-1:0]   device_kind;
    logic [TIME_W-1:0]   time_value;
    logic [BUDGET_W-1:0] budget;
    logic                out_valid;
    logic                out_ready;
    logic [TIME_W-1:0]   next_deadline;
    logic                deadline_valid;
    logic [KIND_W-1:0]   due_kind;
    logic                due_valid;
    logic                yield_request;
    logic [TIME_W-1:0]   current_time;
    logic                overflow;

    device_deadline_timer_queue dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .device_kind(device_kind),
        .time_value(time_value), .budget(budget),
        .out_valid(out_valid), .out_ready(out_ready),
        .next_deadline(next_deadline), .deadline_valid(deadline_valid),
        .due_kind(due_kind), .due_valid(due_valid),
        .yield_request(yield_request), .current_time(current_time),
        .overflow(overflow)
    );

    // model state
    logic [TIME_W-1:0]   hq_dl  [DTQ_HEAP_DEPTH];
    logic [KIND_W-1:0]   hq_kind[DTQ_HEAP_DEPTH];
    logic [GEN_W-1:0]    hq_gen [DTQ_HEAP_DEPTH];
    int                  hq_count;
    logic [GEN_W-1:0]    gen_of [DTQ_KIND_COUNT];
    logic [TIME_W-1:0]   m_now;
    logic                m_slice;
    logic [TIME_W-1:0]   m_base;
    logic [BUDGET_W-1:0] m_budget;
    logic [TIME_W-1:0]   m_target;

    resp_t expected_resp[$];
    int    mismatches;
    int    hold_off;   // long receiver stall, in cycles
    bit    rx_random;

    function automatic logic [GEN_W-1:0] next_gen(logic [GEN_W-1:0] g);
        logic [GEN_W-1:0] n;
        n = g + 1;
        return (n == 0) ? 1 : n;
    endfunction

    task automatic hq_push(logic [TIME_W-1:0] dl, logic [KIND_W-1:0] k,
                           logic [GEN_W-1:0] g);
        int pos;
        int up;
        pos = hq_count;
        hq_count++;
        while (pos > 0) begin
            up = (pos - 1) >> 1;
            if (hq_dl[up] <= dl)
                break;
            hq_dl[pos] = hq_dl[up];
            hq_kind[pos] = hq_kind[up];
            hq_gen[pos] = hq_gen[up];
            pos = up;
        end
        hq_dl[pos] = dl;
        hq_kind[pos] = k;
        hq_gen[pos] = g;
    endtask

    task automatic hq_pop_top();
        int last;
        int pos;
        int c;
        logic [TIME_W-1:0] dl;
        logic [KIND_W-1:0] k;
        logic [GEN_W-1:0]  g;
        pos = 0;
        if (hq_count == 0)
            return;
        last = hq_count - 1;
        dl = hq_dl[last];
        k = hq_kind[last];
        g = hq_gen[last];
        hq_count = last;
        if (last == 0)
            return;
        while (pos < (last >> 1)) begin
            c = 2 * pos + 1;
            if (c + 1 < last && hq_dl[c + 1] < hq_dl[c])
                c++;
            if (hq_dl[c] >= dl)
                break;
            hq_dl[pos] = hq_dl[c];
            hq_kind[pos] = hq_kind[c];
            hq_gen[pos] = hq_gen[c];
            pos = c;
        end
        hq_dl[pos] = dl;
        hq_kind[pos] = k;
        hq_gen[pos] = g;
    endtask

    task automatic discard_stale();
        while (hq_count > 0 && hq_gen[0] != gen_of[hq_kind[0]])
            hq_pop_top();
    endtask

    // predict the response of one request and advance the model
    task automatic predict_timer(logic [OP_W-1:0] op, logic [KIND_W-1:0] k,
                                 logic [TIME_W-1:0] tv, logic [BUDGET_W-1:0] bud);
        resp_t r;
        logic [TIME_W:0] sum;
        r = '0;
        r.current_time = m_now;
        case (op_t'(op))
            OP_SCHEDULE: begin
                gen_of[k] = next_gen(gen_of[k]);
                if (hq_count < DTQ_HEAP_DEPTH)
                    hq_push(tv, k, gen_of[k]);
                else
                    r.overflow = 1'b1;
                r.yield_request = m_slice && (tv <= m_target);
            end
            OP_CANCEL:   gen_of[k] = next_gen(gen_of[k]);
            OP_SET_TIME: begin
                m_now = tv;
                r.current_time = tv;
            end
            OP_POP_DUE: begin
                discard_stale();
                if (hq_count > 0 && hq_dl[0] <= m_now) begin
                    r.due_kind = hq_kind[0];
                    r.due_valid = 1'b1;
                    hq_pop_top();
                end
            end
            OP_BEGIN: begin
                m_slice = 1'b1;
                m_base = m_now;
                m_budget = bud;
                sum = {1'b0, m_now} + bud;
                m_target = sum[TIME_W] ? T_MAX : sum[TIME_W-1:0];
            end
            OP_END:      m_slice = 1'b0;
            OP_READ_TIME:
                if (m_slice)
                    r.current_time = m_base + (TIME_W'(m_budget) - TIME_W'(bud));
            default:     hq_count = 0;
        endcase
        discard_stale();
        if (hq_count > 0) begin
            r.next_deadline = hq_dl[0];
            r.deadline_valid = 1'b1;
        end else begin
            r.next_deadline = T_MAX;
        end
        expected_resp.insert(expected_resp.size(), r);
    endtask

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // send one request; valid holds until accepted, drops only for a gap
    task automatic send_req(logic [OP_W-1:0] op, logic [KIND_W-1:0] k,
                            logic [TIME_W-1:0] tv, logic [BUDGET_W-1:0] bud,
                            bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        device_kind <= k;
        time_value <= tv;
        budget <= bud;
        predict_timer(op, k, tv, bud);
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // receiver: random stalls, plus a long hold-off when requested
    initial begin
        int w;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_off > 0) begin
                out_ready <= 1'b0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
                w = 0;
            end else begin
                w = rx_random ? $urandom_range(0, 4) : 0;
            end
            if (w > 0) begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // response checker
    always @(posedge clk) begin
        resp_t got;
        resp_t exp_r;
        if (rst_n && out_valid && out_ready) begin
            got = '{next_deadline, deadline_valid, due_kind, due_valid,
                    yield_request, current_time, overflow};
            if (expected_resp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %h", got);
            end else begin
                exp_r = expected_resp.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: dl %h/%h dv %b/%b dk %h/%h due %b/%b",
                                  " y %b/%b cur %h/%h ov %b/%b"},
                            exp_r.next_deadline, got.next_deadline,
                            exp_r.deadline_valid, got.deadline_valid,
                            exp_r.due_kind, got.due_kind, exp_r.due_valid, got.due_valid,
                            exp_r.yield_request, got.yield_request,
                            exp_r.current_time, got.current_time,
                            exp_r.overflow, got.overflow);
                end
            end
        end
    end

    function automatic logic [TIME_W-1:0] rand_time();
        logic [TIME_W-1:0] t;
        t = TIME_W'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: return t;
            1: return T_MAX - TIME_W'($urandom_range(0, 50));
            default: return m_now - TIME_W'(100) + TIME_W'($urandom_range(0, 300));
        endcase
    endfunction

    task automatic test_directed();
        send_req(OP_POP_DUE, 0, 0, 0);               // pop on empty
        send_req(OP_READ_TIME, 0, 0, 0);             // read with no slice
        send_req(OP_SCHEDULE, 4'hF, T_MAX, '1);
        send_req(OP_SCHEDULE, 0, 0, 0);
        send_req(OP_POP_DUE, 0, 0, 0);               // due at time zero
        send_req(OP_POP_DUE, 0, 0, 0);               // not due
        send_req(OP_SET_TIME, 0, T_MAX, 0);
        send_req(OP_POP_DUE, 0, 0, 0);
        send_req(OP_SET_TIME, 0, 48'd1000, 0);
        send_req(OP_BEGIN, 0, 0, 31'd500);
        send_req(OP_SCHEDULE, 3, 48'd1500, 0);       // at slice target
        send_req(OP_SCHEDULE, 5, 48'd1501, 0);       // just past it
        send_req(OP_CANCEL, 3, 0, 0);                // stale top
        send_req(OP_READ_TIME, 0, 0, 31'd200);
        send_req(OP_READ_TIME, 0, 0, '1);            // remaining above budget
        send_req(OP_SET_TIME, 0, T_MAX - 5, 0);
        send_req(OP_BEGIN, 0, 0, '1);                // saturated target
        send_req(OP_SCHEDULE, 9, T_MAX, 0);
        send_req(OP_END, 0, 0, 0);
        send_req(OP_SCHEDULE, 2, 48'd7, 0);
        send_req(OP_CLEAR, 0, 0, 0);
        send_req(OP_POP_DUE, 0, 0, 0);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < DTQ_HEAP_DEPTH + 3; i++)
            send_req(OP_SCHEDULE, KIND_W'($urandom_range(0, 15)),
                     TIME_W'({$urandom, $urandom}), 0);
        send_req(OP_SET_TIME, 0, T_MAX, 0);
        for (int i = 0; i < 12; i++)
            send_req(OP_POP_DUE, 0, 0, 0);
        send_req(OP_CLEAR, 0, 0, 0);
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        for (int i = 0; i < 20; i++)
            send_req(OP_SCHEDULE, KIND_W'($urandom_range(0, 15)), rand_time(), 0, 1);
    endtask

    task automatic test_random(int n);
        int o;
        for (int i = 0; i < n; i++) begin
            o = $urandom_range(0, 99);
            if (o < 35)
                send_req(OP_SCHEDULE, KIND_W'($urandom), rand_time(),
                         BUDGET_W'($urandom));
            else if (o < 45)
                send_req(OP_CANCEL, KIND_W'($urandom), TIME_W'($urandom),
                         BUDGET_W'($urandom));
            else if (o < 53)
                send_req(OP_SET_TIME, KIND_W'($urandom), rand_time(),
                         BUDGET_W'($urandom));
            else if (o < 78)
                send_req(OP_POP_DUE, KIND_W'($urandom), TIME_W'($urandom),
                         BUDGET_W'($urandom));
            else if (o < 84)
                send_req(OP_BEGIN, KIND_W'($urandom), TIME_W'($urandom),
                         BUDGET_W'($urandom_range(0, 1) ? $urandom
                                                        : $urandom_range(0, 500)));
            else if (o < 88)
                send_req(OP_END, KIND_W'($urandom), TIME_W'($urandom),
                         BUDGET_W'($urandom));
            else if (o < 98)
                send_req(OP_READ_TIME, KIND_W'($urandom), TIME_W'($urandom),
                         BUDGET_W'($urandom));
            else
                send_req(OP_CLEAR, KIND_W'($urandom), TIME_W'($urandom),
                         BUDGET_W'($urandom));
        end
    endtask

    initial begin
        int guard;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = '0;
        device_kind = '0;
        time_value = '0;
        budget = '0;
        mismatches = 0;
        hold_off = 0;
        rx_random = 1'b0;
        hq_count = 0;
        for (int i = 0; i < DTQ_KIND_COUNT; i++)
            gen_of[i] = '0;
        m_now = '0;
        m_slice = 1'b0;
        m_base = '0;
        m_budget = '0;
        m_target = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        rx_random = 1'b1;
        test_overflow();
        test_backpressure();
        test_random(800);
        rx_random = 1'b0;
        test_random(200);
        rx_random = 1'b1;
        test_random(550);
        in_valid <= 1'b0;
        guard = 0;
        while (expected_resp.size() > 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_resp.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
